// ===== design/fixed_block_free_list_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Free list allocator assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_MACROS_SVH

`define FBFL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define FBFL_ASSERT_IMPLIES(label, ante, cons, msg) \
  `FBFL_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== design/fbfl_pkg.sv =====
// ----------------------------------------------------------------------------
// Free list allocator package
// Shared types, register indexes and codes of the block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfl_pkg;

  localparam int unsigned MaxBlocks = 256;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned BaseW     = 32;
  localparam int unsigned SizeW     = 17;
  localparam int unsigned AddrW     = 48;
  localparam int unsigned ProdW     = IdxW + SizeW;

  localparam logic [BaseW-1:0] ResetBase  = '0;
  localparam logic [SizeW-1:0] ResetSize  = SizeW'(8);
  localparam logic [CntW-1:0]  ResetCount = CntW'(MaxBlocks);

  typedef enum logic [1:0] {
    CfgBase  = 2'd0,
    CfgSize  = 2'd1,
    CfgCount = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ReqAlloc = 1'b0,
    ReqFree  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    StatusDone      = 2'd0,
    StatusExhausted = 2'd1,
    StatusBadFree   = 2'd2
  } status_e;

  typedef struct packed {
    logic [BaseW-1:0] base;
    logic [SizeW-1:0] size;
    logic [CntW-1:0]  count;
  } cfg_t;

  typedef struct packed {
    logic            en;
    logic [CntW-1:0] count;
  } init_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    logic [CntW-1:0] data;
  } link_wr_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdxW-1:0]  gidx;
    logic [AddrW-1:0] gaddr;
    logic [CntW-1:0]  in_use;
  } result_t;

endpackage

`default_nettype wire

// ===== design/fbfl_link_ram.sv =====
// ----------------------------------------------------------------------------
// Free list link memory
// One write port and one registered read port, with write-to-read bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_link_ram (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fbfl_pkg::link_wr_t       wr_i,
  input  logic [fbfl_pkg::IdxW-1:0] rd_addr_i,
  output logic [fbfl_pkg::CntW-1:0] rd_data_o
);
  import fbfl_pkg::*;

  logic [CntW-1:0] mem [MaxBlocks];
  logic [CntW-1:0] rdata_q;
  logic [CntW-1:0] byp_data_q;
  logic            byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q    <= mem[rd_addr_i];
    byp_data_q <= wr_i.data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr_i.en && (wr_i.addr == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rdata_q;

endmodule

`default_nettype wire

// ===== design/fbfl_core.sv =====
// ----------------------------------------------------------------------------
// Free list core
// Head, untouched bound and use count; serves one request per cycle of fire_i.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfl_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic                      req_i,
  input  logic [fbfl_pkg::IdxW-1:0] idx_i,
  input  fbfl_pkg::cfg_t            cfg_i,
  input  fbfl_pkg::init_t           init_i,
  input  logic [fbfl_pkg::CntW-1:0] link_rd_i,
  output fbfl_pkg::link_wr_t        link_wr_o,
  output logic [fbfl_pkg::IdxW-1:0] rd_addr_o,
  output fbfl_pkg::result_t         res_o
);
  import fbfl_pkg::*;

  logic [CntW-1:0]  head_q, head_d;
  logic [CntW-1:0]  bound_q, bound_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [IdxW-1:0]  h;
  logic [CntW-1:0]  h_ext;
  logic [CntW-1:0]  idx_ext;
  logic [ProdW-1:0] prod;

  assign h       = head_q[IdxW-1:0];
  assign h_ext   = {1'b0, h};
  assign idx_ext = {1'b0, idx_i};
  assign prod    = ProdW'(h) * ProdW'(cfg_i.size);

  always_comb begin
    head_d         = head_q;
    bound_d        = bound_q;
    used_d         = used_q;
    link_wr_o      = '0;
    link_wr_o.addr = idx_i;
    link_wr_o.data = head_q;
    res_o          = '0;
    res_o.status   = StatusDone;

    if (req_i == ReqAlloc) begin
      if (used_q < cfg_i.count) begin
        if (h_ext < bound_q) begin
          bound_d = h_ext;
          head_d  = (h == '0) ? '0 : h_ext - CntW'(1);
        end else begin
          head_d  = link_rd_i;
        end
        used_d      = used_q + CntW'(1);
        res_o.gidx  = h;
        res_o.gaddr = AddrW'(cfg_i.base) + AddrW'(prod);
      end else begin
        res_o.status = StatusExhausted;
      end
    end else begin
      if (idx_ext >= cfg_i.count || idx_ext < bound_q || used_q == '0) begin
        res_o.status = StatusBadFree;
      end else begin
        link_wr_o.en = fire_i;
        head_d       = idx_ext;
        used_d       = used_q - CntW'(1);
      end
    end
    res_o.in_use = used_d;

    if (!fire_i) begin
      head_d  = head_q;
      bound_d = bound_q;
      used_d  = used_q;
    end
    if (init_i.en) begin
      bound_d = init_i.count;
      head_d  = (init_i.count == '0) ? '0 : init_i.count - CntW'(1);
      used_d  = '0;
    end
  end

  assign rd_addr_o = head_d[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= ResetCount - CntW'(1);
      bound_q <= ResetCount;
      used_q  <= '0;
    end else begin
      head_q  <= head_d;
      bound_q <= bound_d;
      used_q  <= used_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/fixed_block_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// Fixed block free list allocator
// Pool of equal blocks handed out and taken back through a LIFO free list.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (req_type_i, block_index_i) under
// valid/ready; each gives exactly one result on the out channel (status,
// granted index and address, blocks in use) under valid/ready.
// A request is held in an input register, served by the free list logic
// once the output register is free or being emptied, and lands in the
// output register, which offers the result. One request per cycle is
// sustained while the receiver takes each result; that figure is set by the
// head update loop through the link memory, whose registered read of the
// next head's link is bypassed on a same-cycle free.
// Configuration writes (base, block size, block count) take effect at once;
// the user makes them while no request is in flight, unchecked by the block;
// a block count write re-initialises the pool, all free, highest index first.
// Reset loads base 0, block size 8 and 256 blocks, all free; the link memory
// needs no clearing pass, since a block is only read from it once freed.
// When the receiver stalls, the output holds its result and the input
// register still takes one more request before in_ready_o drops.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [31:0]                cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic [fbfl_pkg::IdxW-1:0]  block_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [fbfl_pkg::IdxW-1:0]  granted_index_o,
  output logic [fbfl_pkg::AddrW-1:0] granted_address_o,
  output logic [fbfl_pkg::CntW-1:0]  blocks_in_use_o
);
  import fbfl_pkg::*;

  `include "fixed_block_free_list_allocator_macros.svh"

  cfg_t            cfg_q;
  init_t           init;
  logic [CntW-1:0] count_wr;

  logic            s1_valid_q;
  logic            s1_req_q;
  logic [IdxW-1:0] s1_idx_q;
  logic            advance;

  logic            out_valid_q;
  result_t         out_q;
  result_t         res;

  link_wr_t        link_wr;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] link_rd;

  assign count_wr   = (cfg_data_i[CntW-1:0] > CntW'(MaxBlocks)) ? CntW'(MaxBlocks)
                                                                : cfg_data_i[CntW-1:0];
  assign init.en    = cfg_we_i && (cfg_index_i == CfgCount);
  assign init.count = count_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base  <= ResetBase;
      cfg_q.size  <= ResetSize;
      cfg_q.count <= ResetCount;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBase:  cfg_q.base  <= cfg_data_i;
        CfgSize:  cfg_q.size  <= cfg_data_i[SizeW-1:0];
        CfgCount: cfg_q.count <= count_wr;
        default:  ;
      endcase
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q <= req_type_i;
      s1_idx_q <= block_index_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  fbfl_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .req_i     (s1_req_q),
    .idx_i     (s1_idx_q),
    .cfg_i     (cfg_q),
    .init_i    (init),
    .link_rd_i (link_rd),
    .link_wr_o (link_wr),
    .rd_addr_o (rd_addr),
    .res_o     (res)
  );

  fbfl_link_ram u_link_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (link_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (link_rd)
  );

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign granted_index_o   = out_q.gidx;
  assign granted_address_o = out_q.gaddr;
  assign blocks_in_use_o   = out_q.in_use;

  `FBFL_ASSERT_IMPLIES(a_in_use_bounded, out_valid_q, out_q.in_use <= cfg_q.count, "in use exceeds pool")
  `FBFL_ASSERT_IMPLIES(a_exhausted_full, out_valid_q && (out_q.status == StatusExhausted), out_q.in_use == cfg_q.count, "exhausted with free blocks")
  `FBFL_ASSERT_IMPLIES(a_full_input_moves, in_valid_i && in_ready_o && s1_valid_q, advance, "transfer into a stalled input register")

endmodule

`default_nettype wire
